### sv/ir2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ir2a_pkg;

   // default word width of the value port
   localparam int VALUE_BITS_DEF = 32;

   // field widths
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 8;

   // radix limits and the one radix that carries a sign
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_BITS-1:0] DEC_RADIX = 6'd10;

   // command codes
   localparam logic CMD_UNSIGNED = 1'b0;
   localparam logic CMD_SIGNED   = 1'b1;

   // character codes
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 8'h00;

   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // classification of one job
   typedef struct packed {
      logic neg;
      logic err;
   } ir2a_flags_type;

   localparam int FLAGS_BITS = $bits(ir2a_flags_type);

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_EMIT,
      ST_ERR
   } ir2a_state_type;

   // digit value to lowercase ascii
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] dx;
      dx = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d < 6'd10) begin
         digit_char = CHAR_ZERO + dx;
      end else begin
         digit_char = CHAR_A + (dx - 8'd10);
      end
   endfunction

endpackage

`default_nettype wire

### sv/integer_to_radix_ascii.sv
// Converts a VALUE_BITS-wide word to ASCII digits in radix 2..36, most
// significant digit first, one character per rsp transfer, lowercase letters
// for digits from 10 up, rsp_last on the final character. A signed command
// with radix 10 and the top bit set gives a leading '-' and the magnitude;
// every other case converts the raw pattern. A radix outside 2..36 gives one
// transfer with rsp_out_char 0, rsp_last and rsp_error set. The back end picks
// up a job from the queue, finds each digit with a bit-serial restoring
// divider, loads the '-' if there is one, then for each character reads the
// digit stack and loads the output register. A two-entry queue lets new
// items be taken while a conversion runs.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii #(
   parameter int VALUE_BITS = ir2a_pkg::VALUE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [VALUE_BITS-1:0]           req_value,
   input  wire logic [ir2a_pkg::RADIX_BITS-1:0] req_radix,
   input  wire logic                            req_cmd,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ir2a_pkg::CHAR_BITS-1:0]       rsp_out_char,
   output logic                                 rsp_last,
   output logic                                 rsp_error
);
   import ir2a_pkg::*;

   localparam int JOB_BITS = VALUE_BITS + RADIX_BITS + FLAGS_BITS;

   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_valid;
   logic [VALUE_BITS-1:0] front_mag;
   logic [RADIX_BITS-1:0] front_radix;
   ir2a_flags_type        front_flags;
   logic [JOB_BITS-1:0]   push_data;
   logic [JOB_BITS-1:0]   q_data;
   logic [VALUE_BITS-1:0] back_mag;
   logic [RADIX_BITS-1:0] back_radix;
   ir2a_flags_type        back_flags;

   // classify incoming items
   ir2a_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_value (req_value),
      .req_radix (req_radix),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .job_mag   (front_mag),
      .job_radix (front_radix),
      .job_flags (front_flags)
   );

   assign push_data = {front_mag, front_radix, front_flags};

   // job queue between front and back
   ir2a_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   assign back_mag   = q_data[JOB_BITS-1 -: VALUE_BITS];
   assign back_radix = q_data[FLAGS_BITS +: RADIX_BITS];
   assign back_flags = q_data[FLAGS_BITS-1:0];

   // divide into digits and stream characters
   ir2a_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .job_mag      (back_mag),
      .job_radix    (back_radix),
      .job_flags    (back_flags),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule

`default_nettype wire

### sv/ir2a_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ir2a_front #(
   parameter int VALUE_BITS = ir2a_pkg::VALUE_BITS_DEF
) (
   input  wire logic                            req_valid,
   input  wire logic [VALUE_BITS-1:0]           req_value,
   input  wire logic [ir2a_pkg::RADIX_BITS-1:0] req_radix,
   input  wire logic                            req_cmd,
   output logic                                 req_stall,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output logic [VALUE_BITS-1:0]                job_mag,
   output logic [ir2a_pkg::RADIX_BITS-1:0]      job_radix,
   output ir2a_pkg::ir2a_flags_type             job_flags
);
   import ir2a_pkg::*;

   logic bad_radix;
   logic is_neg;

   // handshake: take an item whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   // classify radix and sign
   assign bad_radix = (req_radix < RADIX_MIN) | (req_radix > RADIX_MAX);
   assign is_neg    = (req_cmd == CMD_SIGNED) & (req_radix == DEC_RADIX)
                      & req_value[VALUE_BITS-1];

   // magnitude to convert; the most negative word maps onto itself as unsigned
   assign job_mag         = is_neg ? (~req_value + 1'b1) : req_value;
   assign job_radix       = req_radix;
   assign job_flags.neg   = is_neg & ~bad_radix;
   assign job_flags.err   = bad_radix;

endmodule

`default_nettype wire

### sv/ir2a_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ir2a_queue #(
   parameter int WIDTH = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  q_valid,
   output logic [WIDTH-1:0]      q_data
);
   import ir2a_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & q_valid;

   // pointer wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/ir2a_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ir2a_back #(
   parameter int VALUE_BITS = ir2a_pkg::VALUE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire logic [VALUE_BITS-1:0]           job_mag,
   input  wire logic [ir2a_pkg::RADIX_BITS-1:0] job_radix,
   input  wire ir2a_pkg::ir2a_flags_type        job_flags,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ir2a_pkg::CHAR_BITS-1:0]       rsp_out_char,
   output logic                                 rsp_last,
   output logic                                 rsp_error
);
   import ir2a_pkg::*;

   localparam int AW  = $clog2(VALUE_BITS);
   localparam int CW  = $clog2(VALUE_BITS + 1);
   localparam int BCW = $clog2(VALUE_BITS);

   ir2a_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [BCW-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DIGIT_BITS-1:0] rd_digit_ff;

   logic [DIGIT_BITS-1:0] stack_mem [VALUE_BITS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;

   logic                  slot_free;
   logic [DIGIT_BITS:0]   rem_t;
   logic                  ge;
   logic [DIGIT_BITS-1:0] rem_n;
   logic [VALUE_BITS-1:0] quo_n;
   logic                  bit_last;
   logic [CW-1:0]         top_idx;
   logic                  push_digit;
   logic                  load_out;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   // one restoring division step: shift in the next quotient bit
   assign rem_t    = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge       = rem_t >= {1'b0, radix_ff};
   assign rem_n    = ge ? DIGIT_BITS'(rem_t - {1'b0, radix_ff}) : rem_t[DIGIT_BITS-1:0];
   assign quo_n    = {quo_ff[VALUE_BITS-2:0], ge};
   assign bit_last = (bit_cnt_ff == BCW'(VALUE_BITS - 1));
   assign top_idx  = count_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = job_flags.err ? ST_ERR : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (bit_last && (quo_n == '0)) begin
               state_in = neg_ff ? ST_SIGN : ST_READ;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = (count_ff == CW'(1)) ? ST_IDLE : ST_READ;
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and output controls
   always_comb begin
      q_pop       = 1'b0;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      radix_in    = radix_ff;
      neg_in      = neg_ff;
      count_in    = count_ff;
      push_digit  = 1'b0;
      load_out    = 1'b0;
      out_char_in = out_char_ff;
      last_in     = last_ff;
      error_in    = error_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               quo_in     = job_mag;
               rem_in     = '0;
               bit_cnt_in = '0;
               radix_in   = job_radix;
               neg_in     = job_flags.neg;
               count_in   = '0;
            end
         end
         ST_DIVIDE: begin
            quo_in = quo_n;
            if (bit_last) begin
               push_digit = 1'b1;
               count_in   = count_ff + 1'b1;
               rem_in     = '0;
               bit_cnt_in = '0;
            end else begin
               rem_in     = rem_n;
               bit_cnt_in = bit_cnt_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               load_out    = 1'b1;
               out_char_in = CHAR_MINUS;
               last_in     = 1'b0;
               error_in    = 1'b0;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load_out    = 1'b1;
               out_char_in = digit_char(rd_digit_ff);
               last_in     = (count_ff == CW'(1));
               error_in    = 1'b0;
               count_in    = count_ff - 1'b1;
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               load_out    = 1'b1;
               out_char_in = CHAR_NONE;
               last_in     = 1'b1;
               error_in    = 1'b1;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         bit_cnt_ff   <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bit_cnt_ff   <= bit_cnt_in;
         neg_ff       <= neg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
      error_ff    <= error_in;
   end

   // digit stack, least significant digit at the bottom
   always_ff @(posedge clock) begin
      if (push_digit) begin
         stack_mem[count_ff[AW-1:0]] <= rem_n;
      end
      if (state_ff == ST_READ) begin
         rd_digit_ff <= stack_mem[top_idx[AW-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = last_ff;
   assign rsp_error    = error_ff;

endmodule

`default_nettype wire
